// ----- hdl/clcd_pkg.sv -----
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types, codes and the sequencer microprogram for the character LCD
// nibble interface.
// ----------------------------------------------------------------------------
package clcd_pkg;

   localparam int NumSteps = 22;
   localparam int PcWidth  = $clog2(NumSteps);

   localparam logic [9:0] EnPulseUsReset = 10'd20;

   localparam logic [7:0] CursorRow0Base = 8'h80;
   localparam logic [7:0] CursorRow1Base = 8'hC0;

   typedef logic [PcWidth-1:0] pc_type;

   typedef enum logic [2:0] {
      OP_INIT    = 3'd0,
      OP_COMMAND = 3'd1,
      OP_DATA    = 3'd2,
      OP_CURSOR  = 3'd3,
      OP_CLEAR   = 3'd4
   } op_type;

   localparam pc_type EntryInit  = pc_type'(0);
   localparam pc_type EntryByte  = pc_type'(18);
   localparam pc_type EntryClear = pc_type'(20);

   typedef enum logic [1:0] {
      ROW_0 = 2'd0,
      ROW_1 = 2'd1,
      ROW_2 = 2'd2,
      ROW_3 = 2'd3
   } row_type;

   // One control word per emitted nibble
   typedef struct packed {
      logic       use_data;     // nibble from the captured byte, else konst
      logic       high_half;
      logic [3:0] konst;
      logic [5:0] wait_before;
      logic [1:0] wait_after;
      logic       last;         // ends the program, back to idle
   } ucode_type;

   function automatic ucode_type uc(input logic use_data, input logic high_half,
                                    input logic [3:0] konst,
                                    input logic [5:0] wait_before,
                                    input logic [1:0] wait_after,
                                    input logic last);
      ucode_type w;
      w.use_data    = use_data;
      w.high_half   = high_half;
      w.konst       = konst;
      w.wait_before = wait_before;
      w.wait_after  = wait_after;
      w.last        = last;
      return w;
   endfunction

   function automatic ucode_type ucode_rom(input pc_type pc);
      ucode_type w;
      case (pc)
         // power-up sequence: 30 30 30 20 28 08 01 06 0C
         pc_type'(0):  w = uc(1'b0, 1'b1, 4'h3, 6'd50, 2'd0, 1'b0);
         pc_type'(1):  w = uc(1'b0, 1'b0, 4'h0, 6'd0,  2'd0, 1'b0);
         pc_type'(2):  w = uc(1'b0, 1'b1, 4'h3, 6'd5,  2'd0, 1'b0);
         pc_type'(3):  w = uc(1'b0, 1'b0, 4'h0, 6'd0,  2'd0, 1'b0);
         pc_type'(4):  w = uc(1'b0, 1'b1, 4'h3, 6'd1,  2'd0, 1'b0);
         pc_type'(5):  w = uc(1'b0, 1'b0, 4'h0, 6'd0,  2'd0, 1'b0);
         pc_type'(6):  w = uc(1'b0, 1'b1, 4'h2, 6'd10, 2'd0, 1'b0);
         pc_type'(7):  w = uc(1'b0, 1'b0, 4'h0, 6'd0,  2'd0, 1'b0);
         pc_type'(8):  w = uc(1'b0, 1'b1, 4'h2, 6'd10, 2'd0, 1'b0);
         pc_type'(9):  w = uc(1'b0, 1'b0, 4'h8, 6'd0,  2'd0, 1'b0);
         pc_type'(10): w = uc(1'b0, 1'b1, 4'h0, 6'd1,  2'd0, 1'b0);
         pc_type'(11): w = uc(1'b0, 1'b0, 4'h8, 6'd0,  2'd0, 1'b0);
         pc_type'(12): w = uc(1'b0, 1'b1, 4'h0, 6'd1,  2'd0, 1'b0);
         pc_type'(13): w = uc(1'b0, 1'b0, 4'h1, 6'd0,  2'd0, 1'b0);
         pc_type'(14): w = uc(1'b0, 1'b1, 4'h0, 6'd1,  2'd0, 1'b0);
         pc_type'(15): w = uc(1'b0, 1'b0, 4'h6, 6'd0,  2'd0, 1'b0);
         pc_type'(16): w = uc(1'b0, 1'b1, 4'h0, 6'd1,  2'd0, 1'b0);
         pc_type'(17): w = uc(1'b0, 1'b0, 4'hC, 6'd0,  2'd0, 1'b1);
         // command, data and cursor: captured byte
         pc_type'(18): w = uc(1'b1, 1'b1, 4'h0, 6'd0,  2'd0, 1'b0);
         pc_type'(19): w = uc(1'b1, 1'b0, 4'h0, 6'd0,  2'd0, 1'b1);
         // clear display, 2 ms settle
         pc_type'(20): w = uc(1'b0, 1'b1, 4'h0, 6'd0,  2'd0, 1'b0);
         pc_type'(21): w = uc(1'b0, 1'b0, 4'h1, 6'd0,  2'd2, 1'b1);
         default:      w = uc(1'b0, 1'b0, 4'h0, 6'd0,  2'd0, 1'b1);
      endcase
      return w;
   endfunction

endpackage

// ----- hdl/char_lcd_nibble_interface.sv -----
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface
// 4-bit character LCD controller: turns requests into nibble transfers.
// ----------------------------------------------------------------------------
// Each request transaction produces its nibble transfers one per clock while
// the result side is not stalling: two for command, data, cursor and clear,
// eighteen for init; unknown op codes produce none. A new request is taken
// the cycle after the final nibble is loaded into the output register; an
// unknown op code leaves the block idle for the next request. The pace is
// set by the microprogram step counter, which emits one control word per
// cycle while the result side is not stalling; a loaded nibble held by a
// result stall holds the step counter.
// ----------------------------------------------------------------------------
module char_lcd_nibble_interface (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [9:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_op,
   input  logic [7:0] req_byte_value,
   input  logic [1:0] req_row,
   input  logic [6:0] req_column,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [5:0] rsp_wait_before_ms,
   output logic       rsp_register_select,
   output logic [3:0] rsp_nibble,
   output logic [1:0] rsp_wait_after_ms,
   output logic       rsp_last
);
   import clcd_pkg::*;

   logic      busy;
   ucode_type word;
   logic      accept, start, advance;
   pc_type    entry;
   logic      known_op;

   logic [9:0] en_pulse_us_ff, en_pulse_us_in;
   logic [7:0] data_ff, data_in;
   logic       rs_ff, rs_in;
   logic [7:0] cursor_addr;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [5:0] wait_before_ff, wait_before_in;
   logic       register_select_ff, register_select_in;
   logic [3:0] nibble_ff, nibble_in;
   logic [1:0] wait_after_ff, wait_after_in;
   logic       last_ff, last_in;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;
   assign advance   = busy && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      case (row_type'(req_row))
         ROW_0:   cursor_addr = CursorRow0Base | {1'b0, req_column};
         ROW_1:   cursor_addr = CursorRow1Base | {1'b0, req_column};
         default: cursor_addr = {1'b0, req_column};
      endcase
   end

   always_comb begin
      known_op = 1'b1;
      entry    = EntryByte;
      data_in  = data_ff;
      rs_in    = rs_ff;
      case (op_type'(req_op))
         OP_INIT: begin
            entry = EntryInit;
            rs_in = 1'b0;
         end
         OP_COMMAND: begin
            data_in = req_byte_value;
            rs_in   = 1'b0;
         end
         OP_DATA: begin
            data_in = req_byte_value;
            rs_in   = 1'b1;
         end
         OP_CURSOR: begin
            data_in = cursor_addr;
            rs_in   = 1'b0;
         end
         OP_CLEAR: begin
            entry = EntryClear;
            rs_in = 1'b0;
         end
         default: known_op = 1'b0;
      endcase
      if (!accept) begin
         data_in = data_ff;
         rs_in   = rs_ff;
      end
   end

   assign start = accept && known_op;

   clcd_sequencer u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .entry   (entry),
      .advance (advance),
      .busy    (busy),
      .word    (word)
   );

   always_comb begin
      wait_before_in     = wait_before_ff;
      register_select_in = register_select_ff;
      nibble_in          = nibble_ff;
      wait_after_in      = wait_after_ff;
      last_in            = last_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      if (advance) begin
         rsp_valid_in       = 1'b1;
         wait_before_in     = word.wait_before;
         register_select_in = rs_ff;
         wait_after_in      = word.wait_after;
         last_in            = word.last;
         if (word.use_data) begin
            nibble_in = word.high_half ? data_ff[7:4] : data_ff[3:0];
         end else begin
            nibble_in = word.konst;
         end
      end
   end

   assign en_pulse_us_in = csr_wr_en ? csr_wr_data : en_pulse_us_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         en_pulse_us_ff <= EnPulseUsReset;
      end else begin
         rsp_valid_ff   <= rsp_valid_in;
         en_pulse_us_ff <= en_pulse_us_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff            <= data_in;
      rs_ff              <= rs_in;
      wait_before_ff     <= wait_before_in;
      register_select_ff <= register_select_in;
      nibble_ff          <= nibble_in;
      wait_after_ff      <= wait_after_in;
      last_ff            <= last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_wait_before_ms  = wait_before_ff;
   assign rsp_register_select = register_select_ff;
   assign rsp_nibble          = nibble_ff;
   assign rsp_wait_after_ms   = wait_after_ff;
   assign rsp_last            = last_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !advance)
      else $error("held transaction overwritten");

   a_wait_after_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && wait_after_ff != 2'd0 |-> last_ff)
      else $error("settle wait on a non-final nibble");

   a_pulse_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> en_pulse_us_ff == $past(csr_wr_data))
      else $error("enable pulse register not written");

endmodule

// ----- hdl/clcd_sequencer.sv -----
// ----------------------------------------------------------------------------
// clcd_sequencer
// Step counter over the microprogram: starts at an entry point, steps once
// per advance and returns to idle after a word marked last.
// ----------------------------------------------------------------------------
module clcd_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  clcd_pkg::pc_type   entry,
   input  logic               advance,
   output logic               busy,
   output clcd_pkg::ucode_type word
);
   import clcd_pkg::*;

   pc_type pc_ff, pc_in;
   logic   busy_ff, busy_in;

   assign word = ucode_rom(pc_ff);
   assign busy = busy_ff;

   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (start) begin
         pc_in   = entry;
         busy_in = 1'b1;
      end else if (advance) begin
         if (word.last) begin
            busy_in = 1'b0;
         end else begin
            pc_in = pc_ff + pc_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !advance |=> busy_ff && $stable(pc_ff))
      else $error("sequencer moved without advance");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      advance && word.last |=> !busy_ff)
      else $error("sequencer still busy after last step");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> pc_ff < pc_type'(NumSteps))
      else $error("step counter out of program");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("transaction started while busy");

endmodule

// ----- verif/tb_char_lcd_nibble_interface.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_interface
// Self-checking bench for the 4-bit character LCD nibble interface. A short
// table of requests covers every op, the cursor rows, the field extremes and
// the spare op codes; random requests follow under several idle and stall
// mixes, one long output hold-off and several enable pulse widths. Every
// nibble transfer is checked in order against the table or a local block model.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_interface;
   import clcd_pkg::*;

   typedef struct packed {
      logic [5:0] wait_before_ms;
      logic       register_select;
      logic [3:0] nibble;
      logic [1:0] wait_after_ms;
      logic       last;
   } lcd_xfer_type;

   typedef struct packed {
      logic [2:0]   op;
      logic [7:0]   byte_value;
      logic [1:0]   row;
      logic [6:0]   column;
      logic         typed;
      logic [1:0]   typed_count;
      lcd_xfer_type typed_hi;
      lcd_xfer_type typed_lo;
   } lcd_req_type;

   localparam logic [2:0] OpSpare5 = 3'd5;
   localparam logic [2:0] OpSpare6 = 3'd6;
   localparam logic [2:0] OpSpare7 = 3'd7;
   localparam logic       RsInstr  = 1'b0;
   localparam logic       RsData   = 1'b1;
   localparam logic [7:0] ClearCmd = 8'h01;
   localparam logic [1:0] ClearSettleMs = 2'd2;
   localparam lcd_xfer_type NoXfer = '0;
   localparam int         SettleCycles = 25;
   localparam int         HoldOffCycles = 200;
   localparam int         CycleLimit = 200000;

   localparam logic [7:0] PowerUpCmd [9] =
      '{8'h30, 8'h30, 8'h30, 8'h20, 8'h28, 8'h08, 8'h01, 8'h06, 8'h0C};
   localparam logic [5:0] PowerUpWaitMs [9] =
      '{6'd50, 6'd5, 6'd1, 6'd10, 6'd10, 6'd1, 6'd1, 6'd1, 6'd1};

   localparam int DirCount = 19;
   localparam lcd_req_type DirTable [DirCount] = '{
      '{OP_INIT,    8'h00, ROW_0, 7'h00, 1'b0, 2'd0, NoXfer, NoXfer},
      '{OP_COMMAND, 8'h00, ROW_0, 7'h00, 1'b1, 2'd2,
        '{6'd0, RsInstr, 4'h0, 2'd0, 1'b0}, '{6'd0, RsInstr, 4'h0, 2'd0, 1'b1}},
      '{OP_COMMAND, 8'hFF, ROW_3, 7'h7F, 1'b1, 2'd2,
        '{6'd0, RsInstr, 4'hF, 2'd0, 1'b0}, '{6'd0, RsInstr, 4'hF, 2'd0, 1'b1}},
      '{OP_DATA,    8'h00, ROW_0, 7'h00, 1'b1, 2'd2,
        '{6'd0, RsData, 4'h0, 2'd0, 1'b0}, '{6'd0, RsData, 4'h0, 2'd0, 1'b1}},
      '{OP_DATA,    8'hFF, ROW_3, 7'h7F, 1'b1, 2'd2,
        '{6'd0, RsData, 4'hF, 2'd0, 1'b0}, '{6'd0, RsData, 4'hF, 2'd0, 1'b1}},
      '{OP_DATA,    8'hA5, ROW_2, 7'h2A, 1'b0, 2'd0, NoXfer, NoXfer},
      '{OP_COMMAND, 8'h5A, ROW_1, 7'h55, 1'b0, 2'd0, NoXfer, NoXfer},
      '{OP_CURSOR,  8'hFF, ROW_0, 7'h00, 1'b1, 2'd2,
        '{6'd0, RsInstr, 4'h8, 2'd0, 1'b0}, '{6'd0, RsInstr, 4'h0, 2'd0, 1'b1}},
      '{OP_CURSOR,  8'h00, ROW_1, 7'h7F, 1'b1, 2'd2,
        '{6'd0, RsInstr, 4'hF, 2'd0, 1'b0}, '{6'd0, RsInstr, 4'hF, 2'd0, 1'b1}},
      '{OP_CURSOR,  8'hFF, ROW_2, 7'h7F, 1'b1, 2'd2,
        '{6'd0, RsInstr, 4'h7, 2'd0, 1'b0}, '{6'd0, RsInstr, 4'hF, 2'd0, 1'b1}},
      '{OP_CURSOR,  8'h00, ROW_3, 7'h00, 1'b1, 2'd2,
        '{6'd0, RsInstr, 4'h0, 2'd0, 1'b0}, '{6'd0, RsInstr, 4'h0, 2'd0, 1'b1}},
      '{OP_CURSOR,  8'h00, ROW_0, 7'h55, 1'b0, 2'd0, NoXfer, NoXfer},
      '{OP_CURSOR,  8'h00, ROW_1, 7'h2A, 1'b0, 2'd0, NoXfer, NoXfer},
      '{OP_CLEAR,   8'h00, ROW_0, 7'h00, 1'b1, 2'd2,
        '{6'd0, RsInstr, 4'h0, 2'd0, 1'b0}, '{6'd0, RsInstr, 4'h1, 2'd2, 1'b1}},
      '{OP_CLEAR,   8'hFF, ROW_3, 7'h7F, 1'b1, 2'd2,
        '{6'd0, RsInstr, 4'h0, 2'd0, 1'b0}, '{6'd0, RsInstr, 4'h1, 2'd2, 1'b1}},
      '{OpSpare5,   8'hFF, ROW_3, 7'h7F, 1'b1, 2'd0, NoXfer, NoXfer},
      '{OpSpare6,   8'h00, ROW_0, 7'h00, 1'b1, 2'd0, NoXfer, NoXfer},
      '{OpSpare7,   8'h5A, ROW_1, 7'h2A, 1'b1, 2'd0, NoXfer, NoXfer},
      '{OP_INIT,    8'hFF, ROW_3, 7'h7F, 1'b0, 2'd0, NoXfer, NoXfer}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [9:0] csr_wr_data = '0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_op = '0;
   logic [7:0] req_byte_value = '0;
   logic [1:0] req_row = '0;
   logic [6:0] req_column = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [5:0] rsp_wait_before_ms;
   logic       rsp_register_select;
   logic [3:0] rsp_nibble;
   logic [1:0] rsp_wait_after_ms;
   logic       rsp_last;

   lcd_xfer_type lcd_xfer_q [$];
   lcd_xfer_type got_xfer;
   lcd_xfer_type want_xfer;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   logic       hold_off = 1'b0;
   int         error_count = 0;
   int         cycle_count = 0;

   char_lcd_nibble_interface dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_byte_value      (req_byte_value),
      .req_row             (req_row),
      .req_column          (req_column),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_wait_before_ms  (rsp_wait_before_ms),
      .rsp_register_select (rsp_register_select),
      .rsp_nibble          (rsp_nibble),
      .rsp_wait_after_ms   (rsp_wait_after_ms),
      .rsp_last            (rsp_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("char_lcd_nibble_interface test failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall = hold_off || ($urandom_range(99) < recv_stall_pct);
   end

   // one byte as two transfers, high nibble first
   task automatic push_byte(input logic [5:0] wait_before, input logic rs,
                            input logic [7:0] value, input logic [1:0] wait_after,
                            input logic fin);
      lcd_xfer_q.push_back(lcd_xfer_type'{wait_before, rs, value[7:4], 2'd0, 1'b0});
      lcd_xfer_q.push_back(lcd_xfer_type'{6'd0, rs, value[3:0], wait_after, fin});
   endtask

   task automatic predict_xfers(input lcd_req_type req);
      logic [7:0] addr;
      case (req.op)
         OP_INIT: begin
            for (int i = 0; i < 9; i++)
               push_byte(PowerUpWaitMs[i], RsInstr, PowerUpCmd[i], 2'd0, i == 8);
         end
         OP_COMMAND: push_byte(6'd0, RsInstr, req.byte_value, 2'd0, 1'b1);
         OP_DATA:    push_byte(6'd0, RsData, req.byte_value, 2'd0, 1'b1);
         OP_CURSOR: begin
            addr = {1'b0, req.column};
            if (req.row == ROW_0)
               addr = addr | CursorRow0Base;
            else if (req.row == ROW_1)
               addr = addr | CursorRow1Base;
            push_byte(6'd0, RsInstr, addr, 2'd0, 1'b1);
         end
         OP_CLEAR:   push_byte(6'd0, RsInstr, ClearCmd, ClearSettleMs, 1'b1);
         default: ;
      endcase
   endtask

   function automatic lcd_req_type random_req();
      lcd_req_type req;
      int          pick;
      req = '0;
      pick = $urandom_range(99);
      req.byte_value = 8'($urandom_range(255));
      req.row = 2'($urandom_range(3));
      req.column = 7'($urandom_range(127));
      if (pick < 8)
         req.op = OP_INIT;
      else if (pick < 14)
         req.op = 3'($urandom_range(OpSpare7, OpSpare5));
      else if (pick < 50)
         req.op = OP_DATA;
      else if (pick < 70)
         req.op = OP_COMMAND;
      else if (pick < 88)
         req.op = OP_CURSOR;
      else
         req.op = OP_CLEAR;
      return req;
   endfunction

   task automatic send_req(input lcd_req_type req);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_op = req.op;
      req_byte_value = req.byte_value;
      req_row = req.row;
      req_column = req.column;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (!req.typed)
         predict_xfers(req);
      else if (req.typed_count != 0) begin
         lcd_xfer_q.push_back(req.typed_hi);
         lcd_xfer_q.push_back(req.typed_lo);
      end
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_valid = 1'b0;
      while (lcd_xfer_q.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_en_pulse(input logic [9:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic random_burst(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < count; i++)
         send_req(random_req());
      end_burst();
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_xfer = '{rsp_wait_before_ms, rsp_register_select, rsp_nibble,
                      rsp_wait_after_ms, rsp_last};
         if (lcd_xfer_q.size() == 0) begin
            $display("%0t: unexpected transaction %p", $time, got_xfer);
            error_count++;
         end else begin
            want_xfer = lcd_xfer_q.pop_front();
            if (got_xfer.wait_before_ms !== want_xfer.wait_before_ms) begin
               $display("%0t: wait_before_ms expected %0d got %0d", $time,
                        want_xfer.wait_before_ms, got_xfer.wait_before_ms);
               error_count++;
            end
            if (got_xfer.register_select !== want_xfer.register_select) begin
               $display("%0t: register_select expected %0d got %0d", $time,
                        want_xfer.register_select, got_xfer.register_select);
               error_count++;
            end
            if (got_xfer.nibble !== want_xfer.nibble) begin
               $display("%0t: nibble expected %h got %h", $time,
                        want_xfer.nibble, got_xfer.nibble);
               error_count++;
            end
            if (got_xfer.wait_after_ms !== want_xfer.wait_after_ms) begin
               $display("%0t: wait_after_ms expected %0d got %0d", $time,
                        want_xfer.wait_after_ms, got_xfer.wait_after_ms);
               error_count++;
            end
            if (got_xfer.last !== want_xfer.last) begin
               $display("%0t: last expected %0d got %0d", $time,
                        want_xfer.last, got_xfer.last);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_en_pulse(10'd1000);
      for (int i = 0; i < DirCount; i++)
         send_req(DirTable[i]);
      end_burst();

      write_en_pulse(10'd1);
      random_burst(45, 59, 0);
      write_en_pulse(10'd22);
      random_burst(45, 0, 59);
      write_en_pulse(10'($urandom_range(1000, 1)));
      random_burst(45, 25, 25);

      // output held off long enough for the request side to back up
      write_en_pulse(EnPulseUsReset);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      fork
         begin
            @(posedge clock);
            hold_off = 1'b1;
            repeat (HoldOffCycles) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            for (int i = 0; i < 20; i++)
               send_req(random_req());
         end
      join
      end_burst();

      write_en_pulse(10'd1000);
      random_burst(45, 0, 0);

      if (error_count == 0 && lcd_xfer_q.size() == 0)
         $display("char_lcd_nibble_interface test passed");
      else
         $display("char_lcd_nibble_interface test failed");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/clcd_pkg.sv
hdl/clcd_sequencer.sv
hdl/char_lcd_nibble_interface.sv
verif/tb_char_lcd_nibble_interface.sv
